[design/mi3_pkg.sv]
// Shared constants, cofactor index tables and the determinant info word for the 3x3 inverse.
`default_nettype none
package mi3_pkg;
    localparam int ELEM_W_DEF  = 16;
    localparam int OUT_W       = 32;
    localparam int THR_W       = 48;
    localparam int ACC_W       = 64;
    localparam int FRAC_SHIFT  = 28;
    localparam int WIDEN_SHIFT = 4;
    localparam int QBITS       = 33;
    localparam int NUM_ELEM    = 9;
    localparam int FRONT_LAT   = 5;
    localparam int LANE_LAT    = QBITS + 2;
    localparam logic [THR_W-1:0] THR_RESET = 48'd1;
    localparam logic signed [ACC_W-1:0] OUT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [ACC_W-1:0] OUT_MIN = -64'sh0000_0000_8000_0000;

    // cofactor i = e[A]*e[D] - e[B]*e[C]
    localparam logic [3:0] COF_A [NUM_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_D [NUM_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_B [NUM_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_C [NUM_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic [ACC_W-1:0] dmag;
        logic             neg;
        logic             singular;
    } t_det_info;
endpackage
`default_nettype wire

[design/mi3_cofactor.sv]
// Front end: cofactor products, adjugate, determinant and singular test.
`default_nettype none
module mi3_cofactor #(
    parameter int W     = 16,
    parameter int ADJ_W = 33
) (
    input  wire                      i_clk,
    input  wire                      i_en,
    input  wire  [9*W-1:0]           i_elem,
    input  wire  [mi3_pkg::THR_W-1:0] i_thr,
    output logic [9*W-1:0]           o_elem,
    output logic [9*ADJ_W-1:0]       o_adj,
    output mi3_pkg::t_det_info       o_info
);
    import mi3_pkg::*;

    logic signed [W-1:0]       r_e [0:FRONT_LAT-1][0:NUM_ELEM-1];
    logic signed [2*W-1:0]     r_pa [NUM_ELEM];
    logic signed [2*W-1:0]     r_pb [NUM_ELEM];
    logic signed [2*W-1:0]     n_pa [NUM_ELEM];
    logic signed [2*W-1:0]     n_pb [NUM_ELEM];
    logic signed [ADJ_W-1:0]   r_adj2 [NUM_ELEM];
    logic signed [ADJ_W-1:0]   r_adj3 [NUM_ELEM];
    logic signed [ADJ_W-1:0]   r_adj4 [NUM_ELEM];
    logic signed [W+ADJ_W-1:0] n_dp [3];
    logic signed [ACC_W-1:0]   r_dp [3];
    logic signed [ACC_W-1:0]   n_det;
    logic [ACC_W-1:0]          n_dmag;
    t_det_info                 r_info;

    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            n_pa[i] = r_e[0][COF_A[i]] * r_e[0][COF_D[i]];
            n_pb[i] = r_e[0][COF_B[i]] * r_e[0][COF_C[i]];
        end
        for (int j = 0; j < 3; j++) begin
            n_dp[j] = r_e[2][j] * r_adj2[3*j];
        end
        n_det  = r_dp[0] + r_dp[1] + r_dp[2];
        n_dmag = n_det[ACC_W-1] ? ACC_W'(-n_det) : ACC_W'(n_det);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NUM_ELEM; i++) begin
                r_e[0][i] <= i_elem[i*W +: W];
                for (int k = 1; k < FRONT_LAT; k++) begin
                    r_e[k][i] <= r_e[k-1][i];
                end
                r_pa[i]   <= n_pa[i];
                r_pb[i]   <= n_pb[i];
                r_adj2[i] <= ADJ_W'(r_pa[i]) - ADJ_W'(r_pb[i]);
                r_adj3[i] <= r_adj2[i];
                r_adj4[i] <= r_adj3[i];
            end
            for (int j = 0; j < 3; j++) begin
                r_dp[j] <= ACC_W'(n_dp[j]);
            end
            r_info.dmag     <= n_dmag;
            r_info.neg      <= n_det[ACC_W-1];
            r_info.singular <= (n_dmag == '0) || (n_dmag < ACC_W'(i_thr));
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_ELEM; i++) begin
            o_elem[i*W +: W]         = r_e[FRONT_LAT-1][i];
            o_adj[i*ADJ_W +: ADJ_W]  = r_adj4[i];
        end
        o_info = r_info;
    end
endmodule
`default_nettype wire

[design/mi3_div_lane.sv]
// One divider lane: pipelined restoring division of a cofactor by the determinant, round, saturate.
`default_nettype none
module mi3_div_lane #(
    parameter int ADJ_W = 33
) (
    input  wire                         i_clk,
    input  wire                         i_en,
    input  wire  signed [ADJ_W-1:0]     i_adj,
    input  wire  mi3_pkg::t_det_info    i_info,
    output logic [mi3_pkg::OUT_W-1:0]   o_q
);
    import mi3_pkg::*;

    logic [ACC_W-1:0] r_rem [0:QBITS];
    logic [QBITS-1:0] r_low [0:QBITS];
    logic [QBITS-1:0] r_q   [0:QBITS];
    logic [ACC_W-1:0] r_den [0:QBITS];
    logic             r_neg [0:QBITS];
    logic             r_ovf [0:QBITS];

    logic [ACC_W-1:0] n_mag;
    logic [ACC_W-1:0] n_num;
    logic [ACC_W-1:0] n_hi;
    logic             n_rnd;
    logic [QBITS:0]   n_qr;
    logic [OUT_W-1:0] r_q_out;

    always_comb begin
        n_mag = i_adj[ADJ_W-1] ? ACC_W'(-(ACC_W'(i_adj))) : ACC_W'(i_adj);
        n_num = n_mag << FRAC_SHIFT;
        n_hi  = ACC_W'(n_num[ACC_W-1:QBITS]);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= n_hi;
            r_low[0] <= n_num[QBITS-1:0];
            r_q[0]   <= '0;
            r_den[0] <= i_info.dmag;
            r_neg[0] <= i_adj[ADJ_W-1] ^ i_info.neg;
            r_ovf[0] <= n_hi >= i_info.dmag;
        end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_stage
        logic [ACC_W:0] n_t;
        logic           n_ge;
        logic [ACC_W:0] n_d;
        always_comb begin
            n_t  = {r_rem[k-1], r_low[k-1][QBITS-1]};
            n_ge = n_t >= {1'b0, r_den[k-1]};
            n_d  = n_t - {1'b0, r_den[k-1]};
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_ge ? n_d[ACC_W-1:0] : n_t[ACC_W-1:0];
                r_low[k] <= {r_low[k-1][QBITS-2:0], 1'b0};
                r_q[k]   <= {r_q[k-1][QBITS-2:0], n_ge};
                r_den[k] <= r_den[k-1];
                r_neg[k] <= r_neg[k-1];
                r_ovf[k] <= r_ovf[k-1];
            end
        end
    end

    always_comb begin
        n_rnd = {r_rem[QBITS], 1'b0} >= {1'b0, r_den[QBITS]};
        n_qr  = {1'b0, r_q[QBITS]} + (QBITS+1)'(n_rnd);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (r_neg[QBITS]) begin
                if (r_ovf[QBITS] || n_qr >= (QBITS+1)'(34'h0_8000_0000)) begin
                    r_q_out <= 32'h8000_0000;
                end else begin
                    r_q_out <= OUT_W'(-n_qr);
                end
            end else begin
                if (r_ovf[QBITS] || n_qr > (QBITS+1)'(34'h0_7FFF_FFFF)) begin
                    r_q_out <= 32'h7FFF_FFFF;
                end else begin
                    r_q_out <= OUT_W'(n_qr);
                end
            end
        end
    end

    assign o_q = r_q_out;
endmodule
`default_nettype wire

[design/mi3_merge.sv]
// Merge stage: delays the input elements beside the lanes and picks inverse or widened input.
`default_nettype none
module mi3_merge #(
    parameter int W     = 16,
    parameter int DEPTH = 35
) (
    input  wire                             i_clk,
    input  wire                             i_en,
    input  wire  [9*W-1:0]                  i_elem,
    input  wire                             i_singular,
    input  wire  [9*mi3_pkg::OUT_W-1:0]     i_q,
    output logic [9*mi3_pkg::OUT_W-1:0]     o_data,
    output logic                            o_singular
);
    import mi3_pkg::*;

    logic [9*W-1:0] r_elem [0:DEPTH-1];
    logic           r_sing [0:DEPTH-1];
    logic signed [W-1:0]     n_e;
    logic signed [ACC_W-1:0] n_v;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_elem[0] <= i_elem;
            r_sing[0] <= i_singular;
            for (int k = 1; k < DEPTH; k++) begin
                r_elem[k] <= r_elem[k-1];
                r_sing[k] <= r_sing[k-1];
            end
        end
    end

    always_comb begin
        n_e = '0;
        n_v = '0;
        for (int i = 0; i < NUM_ELEM; i++) begin
            n_e = r_elem[DEPTH-1][i*W +: W];
            n_v = ACC_W'(n_e) <<< WIDEN_SHIFT;
            if (!r_sing[DEPTH-1]) begin
                o_data[i*OUT_W +: OUT_W] = i_q[i*OUT_W +: OUT_W];
            end else if (n_v > OUT_MAX) begin
                o_data[i*OUT_W +: OUT_W] = OUT_MAX[OUT_W-1:0];
            end else if (n_v < OUT_MIN) begin
                o_data[i*OUT_W +: OUT_W] = OUT_MIN[OUT_W-1:0];
            end else begin
                o_data[i*OUT_W +: OUT_W] = n_v[OUT_W-1:0];
            end
        end
        o_singular = r_sing[DEPTH-1];
    end
endmodule
`default_nettype wire

[design/matrix_inverse_3x3.sv]
// Top level: 3x3 matrix inverse by adjugate over determinant, nine lanes, stream ports.
// Usage:
//   Input words on the i_s_* stream carry nine signed Q4.12 elements, row-major.
//   Output words on the o_m_* stream carry nine saturated Q16.16 inverse elements
//   in tdata and the singular flag in tuser. A singular matrix (determinant magnitude
//   below the threshold, or zero) comes back widened with tuser high. The user writes
//   the threshold through i_cfg_* (always ready) while the block idles; not enforced.
// Timing:
//   One word accepted per cycle while o_s_tready is high. On its way to o_m_tvalid,
//   a word passes five front stages (input register, cofactor products, adjugate,
//   determinant products, sum and threshold test), 35 in each divider lane (one
//   quotient bit per stage, 33 stages, plus entry and rounding), one output register.
// Stalls:
//   While the output word waits, the pipe keeps accepting until its last stage
//   holds a word; then o_s_tready drops until the output word is taken.
// Reset:
//   Clears all valid bits and sets the threshold to 1; no clearing pass.
`default_nettype none
module matrix_inverse_3x3 #(
    parameter int ELEM_WIDTH = mi3_pkg::ELEM_W_DEF
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_s_tvalid,
    output logic                             o_s_tready,
    // elem_r0c0, elem_r0c1, ..., elem_r2c2, zero pad
    input  wire  [((9*ELEM_WIDTH+7)/8)*8-1:0] i_s_tdata,
    output logic                             o_m_tvalid,
    input  wire                              i_m_tready,
    // inv_r0c0, inv_r0c1, ..., inv_r2c2
    output logic [9*mi3_pkg::OUT_W-1:0]      o_m_tdata,
    // singular
    output logic                             o_m_tuser,
    input  wire                              i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire  [mi3_pkg::THR_W-1:0]        i_cfg_data
);
    import mi3_pkg::*;

    localparam int ADJ_W = (2*ELEM_WIDTH+1 > ACC_W) ? ACC_W : 2*ELEM_WIDTH+1;
    localparam int TOTAL = FRONT_LAT + LANE_LAT;

    logic [THR_W-1:0]          r_thr;
    logic [TOTAL-1:0]          r_vld;
    logic                      r_out_valid;
    logic [9*OUT_W-1:0]        r_out_data;
    logic                      r_out_user;
    logic                      n_en;
    logic [9*ELEM_WIDTH-1:0]   w_elem;
    logic [9*ADJ_W-1:0]        w_adj;
    t_det_info                 w_info;
    logic [9*OUT_W-1:0]        w_q;
    logic [9*OUT_W-1:0]        w_data;
    logic                      w_sing;

    assign n_en        = !(r_vld[TOTAL-1] && r_out_valid && !i_m_tready);
    assign o_s_tready  = n_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (n_en) begin
                r_vld <= {r_vld[TOTAL-2:0], i_s_tvalid};
            end
            if (n_en && r_vld[TOTAL-1]) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_en && r_vld[TOTAL-1]) begin
            r_out_data <= w_data;
            r_out_user <= w_sing;
        end
    end

    mi3_cofactor #(.W(ELEM_WIDTH), .ADJ_W(ADJ_W)) u_front (
        .i_clk  (i_clk),
        .i_en   (n_en),
        .i_elem (i_s_tdata[9*ELEM_WIDTH-1:0]),
        .i_thr  (r_thr),
        .o_elem (w_elem),
        .o_adj  (w_adj),
        .o_info (w_info)
    );

    for (genvar i = 0; i < NUM_ELEM; i++) begin : g_lane
        mi3_div_lane #(.ADJ_W(ADJ_W)) u_lane (
            .i_clk  (i_clk),
            .i_en   (n_en),
            .i_adj  (w_adj[i*ADJ_W +: ADJ_W]),
            .i_info (w_info),
            .o_q    (w_q[i*OUT_W +: OUT_W])
        );
    end

    mi3_merge #(.W(ELEM_WIDTH), .DEPTH(LANE_LAT)) u_merge (
        .i_clk      (i_clk),
        .i_en       (n_en),
        .i_elem     (w_elem),
        .i_singular (w_info.singular),
        .i_q        (w_q),
        .o_data     (w_data),
        .o_singular (w_sing)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[TOTAL-1] && r_out_valid && !i_m_tready) |-> !o_s_tready)
        else $error("input accepted while full pipe is blocked");

    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(r_vld[TOTAL-1]))
        else $error("output word without a finished pipe word");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_m_tvalid && r_vld == '0))
        else $error("pipe not empty after reset");
endmodule
`default_nettype wire

[tb/matrix_inverse_3x3_checker.sv]
// Checker for the 3x3 inverse: watches both streams, predicts each result word and compares.
`default_nettype none
module matrix_inverse_3x3_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_s_tvalid,
    input  wire                 i_s_tready,
    input  wire [9*16-1:0]      i_s_tdata,
    input  wire                 i_m_tvalid,
    input  wire                 i_m_tready,
    input  wire [9*32-1:0]      i_m_tdata,
    input  wire                 i_m_tuser,
    input  wire                 i_cfg_valid,
    input  wire                 i_cfg_ready,
    input  wire [47:0]          i_cfg_data,
    output int                  o_errors,
    output int                  o_pending
);
    import mi3_pkg::*;

    typedef struct packed {
        logic [9*32-1:0] elems;
        logic            singular;
    } t_inv_word;

    t_inv_word       inv_queue[$];
    logic [47:0]     threshold;

    function automatic logic [31:0] sat_word(logic neg, logic [63:0] mag);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-mag);
        return (mag > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic t_inv_word invert(logic [9*16-1:0] din, logic [47:0] thr);
        logic signed [63:0] m [9];
        logic signed [63:0] cof [9];
        logic signed [63:0] det;
        logic [63:0] dmag, num, quo, rem;
        t_inv_word w;
        for (int i = 0; i < 9; i++)
            m[i] = 64'(signed'(din[i*16 +: 16]));
        cof[0] = m[4]*m[8] - m[5]*m[7];
        cof[1] = m[2]*m[7] - m[1]*m[8];
        cof[2] = m[1]*m[5] - m[2]*m[4];
        cof[3] = m[5]*m[6] - m[3]*m[8];
        cof[4] = m[0]*m[8] - m[2]*m[6];
        cof[5] = m[2]*m[3] - m[0]*m[5];
        cof[6] = m[3]*m[7] - m[4]*m[6];
        cof[7] = m[1]*m[6] - m[0]*m[7];
        cof[8] = m[0]*m[4] - m[1]*m[3];
        det = m[0]*cof[0] + m[1]*cof[3] + m[2]*cof[6];
        dmag = mag64(det);
        w.singular = (dmag == 0) || (dmag < {16'd0, thr});
        for (int i = 0; i < 9; i++) begin
            if (w.singular) begin
                w.elems[i*32 +: 32] = sat_word(m[i][63], mag64(m[i]) << WIDEN_SHIFT);
            end else begin
                num = mag64(cof[i]) << FRAC_SHIFT;
                quo = num / dmag;
                rem = num % dmag;
                if (rem >= dmag - rem)
                    quo++;
                w.elems[i*32 +: 32] = sat_word(cof[i][63] != det[63], quo);
            end
        end
        return w;
    endfunction

    assign o_pending = inv_queue.size();

    always @(posedge i_clk) begin
        t_inv_word exp_w;
        if (!i_rst_n) begin
            threshold <= THR_RESET;
            o_errors  <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready)
                threshold <= i_cfg_data;
            if (i_s_tvalid && i_s_tready)
                inv_queue.push_back(invert(i_s_tdata, threshold));
            if (i_m_tvalid && i_m_tready) begin
                if (inv_queue.size() == 0) begin
                    if (o_errors < 10)
                        $display("unexpected word: %h tuser %b", i_m_tdata, i_m_tuser);
                    o_errors <= o_errors + 1;
                end else begin
                    exp_w = inv_queue.pop_front();
                    if (exp_w != {i_m_tdata, i_m_tuser}) begin
                        if (o_errors < 10)
                            $display("mismatch: exp %h/%b got %h/%b", exp_w.elems,
                                     exp_w.singular, i_m_tdata, i_m_tuser);
                        o_errors <= o_errors + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

[tb/matrix_inverse_3x3_tb.sv]
// Testbench top: drives matrices and threshold writes into the 3x3 inverse and gives the verdict.
`default_nettype none
module matrix_inverse_3x3_tb;
    localparam int LATENCY = 41;
    localparam int LIMIT   = 400000;

    logic            i_clk = 0;
    logic            i_rst_n = 0;
    logic            s_tvalid = 0;
    logic            s_tready;
    logic [143:0]    s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 0;
    logic [287:0]    m_tdata;
    logic            m_tuser;
    logic            cfg_valid = 0;
    logic            cfg_ready;
    logic [47:0]     cfg_data = '0;
    int              errors, pending;
    int              cycles = 0;
    int              hold_cycles = 0;
    bit              random_ready = 0;

    always #4 i_clk = ~i_clk;

    matrix_inverse_3x3 dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready), .i_s_tdata(s_tdata),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready), .o_m_tdata(m_tdata),
        .o_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_data(cfg_data)
    );

    matrix_inverse_3x3_checker chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready), .i_s_tdata(s_tdata),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready), .i_m_tdata(m_tdata),
        .i_m_tuser(m_tuser),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            m_tready <= 0;
            hold_cycles <= hold_cycles - 1;
        end else if (random_ready) begin
            m_tready <= ($urandom_range(0, 3) != 0) || ($urandom_range(0, 9) == 0);
        end else begin
            m_tready <= 1;
        end
    end

    // tvalid stays high between back-to-back words; drain() drops it
    task automatic send_word(logic [143:0] d);
        int g;
        g = gap_len();
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
        s_tvalid <= 1;
        s_tdata  <= d;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
    endtask

    task automatic drain();
        s_tvalid <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_threshold(logic [47:0] v);
        drain();
        cfg_valid <= 1;
        cfg_data  <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 0;
        @(posedge i_clk);
    endtask

    function automatic logic [15:0] rand_elem();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'(signed'($urandom_range(0, 8191)) - 4096);
            3: return 16'(signed'($urandom_range(0, 255)) - 128);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [143:0] rand_matrix();
        logic [143:0] d;
        int k;
        for (int i = 0; i < 9; i++) d[i*16 +: 16] = rand_elem();
        k = $urandom_range(0, 9);
        if (k == 0) begin
            // dependent rows: row 2 copies row 0
            d[96 +: 48] = d[0 +: 48];
        end else if (k == 1) begin
            // near diagonal: random diagonal, one small off-diagonal element
            d = '0;
            for (int i = 0; i < 3; i++)
                d[(i*4)*16 +: 16] = 16'($urandom_range(1, 32767));
            d[16 +: 16] = 16'($urandom_range(0, 15));
        end
        return d;
    endfunction

    function automatic logic [143:0] diag(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        logic [143:0] d;
        d = '0;
        d[0 +: 16] = a;
        d[64 +: 16] = b;
        d[128 +: 16] = c;
        return d;
    endfunction

    initial begin
        logic [47:0] thr;
        random_ready = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed
        send_word(diag(16'h1000, 16'h1000, 16'h1000));
        send_word(diag(16'h0001, 16'h0001, 16'h0001));
        send_word(diag(16'h0010, 16'h0010, 16'h0010));
        send_word(diag(16'h8000, 16'h8000, 16'h8000));
        send_word(diag(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_word(diag(16'h7FFF, 16'h8000, 16'h0001));
        send_word('0);
        send_word({9{16'h7FFF}});
        send_word({9{16'h8000}});
        send_word({9{16'hFFFF}});
        send_word({16'h1000, 16'h2000, 16'h3000, 16'h4000, 16'h5000,
                   16'h6000, 16'h7000, 16'h8000, 16'h9000});
        send_word({16'h0002, 16'h0001, 16'h0000, 16'h0001, 16'h0003,
                   16'h0001, 16'h0000, 16'h0001, 16'h0004});
        send_word({16'h0001, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000,
                   16'h0000, 16'h0003, 16'h0000, 16'h7FFF});
        // threshold zero: only exactly singular matrices pass through
        write_threshold(48'd0);
        send_word(diag(16'h0001, 16'h0001, 16'h0001));
        send_word('0);
        send_word({9{16'h1234}});
        write_threshold({48{1'b1}});
        send_word(diag(16'h7FFF, 16'h7FFF, 16'h7FFF));
        send_word(diag(16'h8000, 16'h8000, 16'h8000));
        send_word({9{16'h7FFF}});
        write_threshold(48'd1 << 36);
        send_word(diag(16'h1000, 16'h1000, 16'h1000));
        send_word(diag(16'h1000, 16'h1000, 16'h0FFF));
        send_word(diag(16'hF000, 16'h1000, 16'h1000));

        random_ready = 1;
        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0: thr = 48'd1;
                1: thr = 48'd0;
                2: thr = 48'($urandom_range(0, 65535)) << $urandom_range(0, 32);
                3: thr = {48{1'b1}};
                4: thr = 48'({$urandom, $urandom});
                default: thr = 48'd1 << 30;
            endcase
            write_threshold(thr);
            if (ph == 2) hold_cycles <= 300;
            for (int n = 0; n < 255; n++)
                send_word(rand_matrix());
        end

        drain();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
`default_nettype wire

[files.f]
design/mi3_pkg.sv
design/mi3_cofactor.sv
design/mi3_div_lane.sv
design/mi3_merge.sv
design/matrix_inverse_3x3.sv
tb/matrix_inverse_3x3_checker.sv
tb/matrix_inverse_3x3_tb.sv
